>>> rtl/ptta_pkg.sv
// ----------------------------------------------------------------------------
// ptta_pkg
// Shared types and constants of the peer table with TTL aging.
// ----------------------------------------------------------------------------
package ptta_pkg;

    localparam int ID_W    = 48;
    localparam int TTL_W   = 8;
    localparam int ACT_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 5;

    typedef logic [ID_W-1:0]    t_node_id;
    typedef logic [TTL_W-1:0]   t_ttl;
    typedef logic [ACT_W-1:0]   t_action_bits;
    typedef logic [SLOT_W-1:0]  t_slot;
    typedef logic [COUNT_W-1:0] t_count;

    // Item opcodes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_LOOKUP  = 1'b1;

    // Result actions
    typedef enum logic [ACT_W-1:0] {
        ACT_REFRESH = 2'd0,
        ACT_INSERT  = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    localparam t_ttl TTL_FULL = 8'hFF;

endpackage

>>> rtl/ptta_in_if.sv
// ----------------------------------------------------------------------------
// ptta_in_if
// Input channel: one lookup or observe item per handshake.
// ----------------------------------------------------------------------------
interface ptta_in_if;
    import ptta_pkg::*;

    logic     valid;
    logic     ready;
    logic     opcode;
    t_node_id node_id;

    modport source (output valid, output opcode, output node_id, input ready);
    modport sink   (input valid, input opcode, input node_id, output ready);
endinterface

>>> rtl/ptta_out_if.sv
// ----------------------------------------------------------------------------
// ptta_out_if
// Result channel: one result item per input item.
// ----------------------------------------------------------------------------
interface ptta_out_if;
    import ptta_pkg::*;

    logic         valid;
    logic         ready;
    logic         hit;
    t_action_bits action;
    t_slot        slot;
    t_node_id     evicted_id;
    t_count       peer_count;

    modport source (output valid, output hit, output action, output slot,
                    output evicted_id, output peer_count, input ready);
    modport sink   (input valid, input hit, input action, input slot,
                    input evicted_id, input peer_count, output ready);
endinterface

>>> rtl/ptta_cell.sv
// ----------------------------------------------------------------------------
// ptta_cell
// One table entry (node id and TTL) in the rotating ring of entries.
// ----------------------------------------------------------------------------
module ptta_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  ptta_pkg::t_node_id i_id,
    input  ptta_pkg::t_ttl     i_ttl,
    output ptta_pkg::t_node_id o_id,
    output ptta_pkg::t_ttl     o_ttl
);
    import ptta_pkg::*;

    t_node_id r_id;
    t_ttl     r_ttl;

    // Take the neighbor's entry on every shift; reset empties the slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= '0;
            r_ttl <= '0;
        end else if (i_shift) begin
            r_id  <= i_id;
            r_ttl <= i_ttl;
        end
    end

    assign o_id  = r_id;
    assign o_ttl = r_ttl;

endmodule

>>> rtl/peer_table_ttl_aging.sv
// ----------------------------------------------------------------------------
// peer_table_ttl_aging
// Neighbor table with TTL aging and lowest-TTL replacement.
// ----------------------------------------------------------------------------
// The entries sit in a ring of cells that rotates one place per cycle, while
// scanning or writing, past a single head unit. A lookup takes one full
// rotation, then the decide and done states. An observe item also takes one
// rotation to refresh, age, find the first empty slot and the lowest TTL; when
// it must insert or replace, a second rotation writes the chosen slot. One item
// is in work at a time; the result sits in an output register so the next item
// may enter while it waits. The table is empty right after reset.
// ----------------------------------------------------------------------------
module peer_table_ttl_aging #(
    parameter int TABLE_ENTRIES = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ptta_in_if.sink   i_in,
    ptta_out_if.source o_out
);
    import ptta_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state, n_state;
    logic [IW-1:0] r_idx;

    // Item being worked on
    logic     r_op;
    t_node_id r_node_id;

    // First-pass trackers
    logic          r_found;
    logic [IW-1:0] r_match_idx;
    logic          r_have_empty;
    logic [IW-1:0] r_empty_idx;
    t_ttl          r_min_ttl;
    logic [IW-1:0] r_min_idx;
    t_node_id      r_min_id;
    logic [CW-1:0] r_count;

    // Result being built and write target
    logic          r_res_hit;
    t_action_bits  r_res_action;
    logic [IW-1:0] r_res_slot;
    t_node_id      r_res_evict;
    logic [CW-1:0] r_res_count;

    // Output register
    logic          r_out_valid;
    logic          r_o_hit;
    t_action_bits  r_o_action;
    t_slot         r_o_slot;
    t_node_id      r_o_evict;
    t_count        r_o_count;

    // Ring of cells
    t_node_id w_id  [TABLE_ENTRIES];
    t_ttl     w_ttl [TABLE_ENTRIES];
    t_node_id head_id;
    t_ttl     head_ttl;
    logic     shift;

    assign shift = (r_state == S_SCAN) || (r_state == S_WRITE);

    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        if (k == TABLE_ENTRIES - 1) begin : g_tail
            ptta_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_id    (head_id),
                .i_ttl   (head_ttl),
                .o_id    (w_id[k]),
                .o_ttl   (w_ttl[k])
            );
        end else begin : g_body
            ptta_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_id    (w_id[k+1]),
                .i_ttl   (w_ttl[k+1]),
                .o_id    (w_id[k]),
                .o_ttl   (w_ttl[k])
            );
        end
    end

    // Head unit: the entry at cell 0 has index r_idx
    logic h_match;
    logic h_empty;
    logic is_first;
    t_ttl h_aged;

    assign h_match  = (r_node_id != '0) && (w_id[0] == r_node_id);
    assign h_empty  = (w_id[0] == '0);
    assign is_first = (r_idx == '0);
    assign h_aged   = (w_ttl[0] != '0) ? (w_ttl[0] - 8'd1) : '0;

    always_comb begin
        head_id  = w_id[0];
        head_ttl = w_ttl[0];
        if (r_state == S_SCAN && r_op == OP_OBSERVE) begin
            head_ttl = h_match ? TTL_FULL : h_aged;
        end else if (r_state == S_WRITE && r_idx == r_res_slot) begin
            head_id  = r_node_id;
            head_ttl = TTL_FULL;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in.valid) n_state = S_SCAN;
            S_SCAN:   if (r_idx == LAST_IDX) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_op == OP_OBSERVE && !r_found && r_node_id != '0) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WRITE:  if (r_idx == LAST_IDX) n_state = S_DONE;
            S_DONE:   if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (shift) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_op      <= i_in.opcode;
            r_node_id <= i_in.node_id;
        end
    end

    // First-pass scan: match, first empty, lowest TTL (after aging on an observe), count
    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            if (h_match && (is_first || !r_found)) begin
                r_found     <= 1'b1;
                r_match_idx <= r_idx;
            end else if (is_first) begin
                r_found     <= 1'b0;
                r_match_idx <= '0;
            end
            if (h_empty && (is_first || !r_have_empty)) begin
                r_have_empty <= 1'b1;
                r_empty_idx  <= r_idx;
            end else if (is_first) begin
                r_have_empty <= 1'b0;
                r_empty_idx  <= '0;
            end
            if (is_first || head_ttl < r_min_ttl) begin
                r_min_ttl <= head_ttl;
                r_min_idx <= r_idx;
                r_min_id  <= w_id[0];
            end
            r_count <= (is_first ? '0 : r_count) + CW'(!h_empty);
        end
    end

    // Result decision after the first pass
    always_ff @(posedge i_clk) begin
        if (r_state == S_DECIDE) begin
            r_res_hit    <= 1'b0;
            r_res_action <= ACT_NONE;
            r_res_slot   <= '0;
            r_res_evict  <= '0;
            r_res_count  <= r_count;
            if (r_found) begin
                r_res_hit    <= 1'b1;
                r_res_slot   <= r_match_idx;
                r_res_action <= (r_op == OP_OBSERVE) ? ACT_REFRESH : ACT_NONE;
            end else if (r_op == OP_OBSERVE && r_node_id != '0) begin
                if (r_have_empty) begin
                    r_res_action <= ACT_INSERT;
                    r_res_slot   <= r_empty_idx;
                    r_res_count  <= r_count + 1'b1;
                end else begin
                    r_res_action <= ACT_REPLACE;
                    r_res_slot   <= r_min_idx;
                    r_res_evict  <= r_min_id;
                end
            end
        end
    end

    // Output register load
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_out_valid || o_out.ready)) begin
            r_o_hit    <= r_res_hit;
            r_o_action <= r_res_action;
            r_o_slot   <= SLOT_W'(r_res_slot);
            r_o_evict  <= r_res_evict;
            r_o_count  <= COUNT_W'(r_res_count);
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.hit        = r_o_hit;
    assign o_out.action     = r_o_action;
    assign o_out.slot       = r_o_slot;
    assign o_out.evicted_id = r_o_evict;
    assign o_out.peer_count = r_o_count;

endmodule
